@@ rtl/i2cmra_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cmra_pkg
// Shared types and codes for the i2c master register access sequencer:
// item modes, engine commands, engine status codes, sequencer phases and
// the beat, context and result structs.
// ----------------------------------------------------------------------------
package i2cmra_pkg;

	// item modes
	typedef enum logic [1:0] {
		MODE_WRITE     = 2'd0,
		MODE_READ      = 2'd1,
		MODE_EVENT     = 2'd2,
		MODE_STOP_DONE = 2'd3
	} mode_t;

	// commands to the byte-level engine
	typedef enum logic [2:0] {
		CMD_NONE    = 3'd0,
		CMD_START   = 3'd1,
		CMD_SEND    = 3'd2,
		CMD_RX_ACK  = 3'd3,
		CMD_RX_NACK = 3'd4,
		CMD_STOP    = 3'd5
	} cmd_t;

	// sequencer phases
	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_WSTART    = 4'd1,
		PH_WSLA      = 4'd2,
		PH_WADDR     = 4'd3,
		PH_WDATA     = 4'd4,
		PH_RSTART    = 4'd5,
		PH_RSLA      = 4'd6,
		PH_RDATA     = 4'd7,
		PH_STOP_OK   = 4'd8,
		PH_STOP_FAIL = 4'd9
	} phase_t;

	// engine status codes, low three bits masked off
	localparam logic [7:0] STATUS_MASK = 8'hF8;
	localparam logic [7:0] ST_START    = 8'h08;
	localparam logic [7:0] ST_RSTART   = 8'h10;
	localparam logic [7:0] ST_SLAW_ACK = 8'h18;
	localparam logic [7:0] ST_DATA_ACK = 8'h28;
	localparam logic [7:0] ST_SLAR_ACK = 8'h40;
	localparam logic [7:0] ST_RX_ACK   = 8'h50;
	localparam logic [7:0] ST_RX_NACK  = 8'h58;

	localparam logic       READ_BIT       = 1'b1;
	localparam logic [2:0] MAX_ADDR_BYTES = 3'd4;

	// one input beat
	typedef struct packed {
		mode_t        mode;
		logic [6:0]   slave_addr;
		logic [31:0]  reg_addr;
		logic [2:0]   reg_addr_bytes;
		logic [15:0]  byte_count;
		logic [7:0]   bus_status;
		logic [7:0]   rx_byte;
		logic [7:0]   tx_byte;
	} item_t;

	// transaction context
	typedef struct packed {
		phase_t       phase;
		logic         read_pending;
		logic [6:0]   target_addr;
		logic [31:0]  internal_addr;
		logic [2:0]   addr_bytes_total;
		logic [2:0]   addr_bytes_sent;
		logic [15:0]  remaining;
		logic [15:0]  data_index;
	} ctx_t;

	// one result beat
	typedef struct packed {
		cmd_t         command;
		logic [7:0]   command_byte;
		logic         tx_taken;
		logic         rx_valid;
		logic [7:0]   rx_data;
		logic [15:0]  byte_index;
		logic         done_res;
		logic         failed;
	} res_t;

endpackage

@@ rtl/i2cmra_step.sv @@
// ----------------------------------------------------------------------------
// i2cmra_step
// Per-beat decision logic: from the current context and one input beat,
// works out the next context and the result beat (command, byte, status).
// ----------------------------------------------------------------------------
module i2cmra_step (
	input  i2cmra_pkg::item_t item,
	input  i2cmra_pkg::ctx_t  ctx,
	output i2cmra_pkg::ctx_t  ctx_next,
	output i2cmra_pkg::res_t  res
);
	import i2cmra_pkg::*;

	logic [7:0]  st;
	logic        addr_more;
	logic        wr_more;
	logic        addr_ok;
	logic        rx_ok;
	logic [15:0] rem_dec;
	logic        rx_last;
	logic [2:0]  nb_sat;
	logic        stopping;
	logic [7:0]  addr_byte;

	// shared conditions
	assign st        = item.bus_status & STATUS_MASK;
	assign addr_more = ctx.addr_bytes_sent < ctx.addr_bytes_total;
	assign wr_more   = !ctx.read_pending && (ctx.remaining != 16'd0);
	assign addr_ok   = (ctx.phase == PH_WSLA) ? (st == ST_SLAW_ACK) : (st == ST_DATA_ACK);
	assign rx_ok     = (st == ST_RX_ACK) || (st == ST_RX_NACK);
	assign rem_dec   = (ctx.remaining != 16'd0) ? ctx.remaining - 16'd1 : ctx.remaining;
	assign rx_last   = (st == ST_RX_NACK) || (rem_dec == 16'd0);
	assign nb_sat    = (item.reg_addr_bytes > MAX_ADDR_BYTES) ? MAX_ADDR_BYTES
	                                                         : item.reg_addr_bytes;
	assign stopping  = (ctx.phase == PH_STOP_OK) || (ctx.phase == PH_STOP_FAIL);
	assign addr_byte = ctx.internal_addr[{ctx.addr_bytes_sent[1:0], 3'b000} +: 8];

	// next context
	always_comb begin
		ctx_next = ctx;
		unique case (item.mode)
			MODE_WRITE, MODE_READ: begin
				ctx_next.target_addr      = item.slave_addr;
				ctx_next.internal_addr    = item.reg_addr;
				ctx_next.addr_bytes_total = nb_sat;
				ctx_next.addr_bytes_sent  = 3'd0;
				ctx_next.remaining        = item.byte_count;
				ctx_next.data_index       = 16'd0;
				if (item.mode == MODE_READ && nb_sat == 3'd0) begin
					ctx_next.read_pending = 1'b0;
					ctx_next.phase        = PH_RSTART;
				end else begin
					ctx_next.read_pending = (item.mode == MODE_READ);
					ctx_next.phase        = PH_WSTART;
				end
			end
			MODE_STOP_DONE: begin
				if (stopping) begin
					if (ctx.read_pending) begin
						ctx_next.read_pending = 1'b0;
						ctx_next.phase        = PH_RSTART;
					end else begin
						ctx_next.phase = PH_IDLE;
					end
				end
			end
			MODE_EVENT: begin
				unique case (ctx.phase) inside
					PH_WSTART: begin
						if (st == ST_START) begin
							ctx_next.phase = PH_WSLA;
						end else if (ctx.read_pending) begin
							ctx_next.read_pending = 1'b0;
							ctx_next.phase        = PH_RSTART;
						end else begin
							ctx_next.phase = PH_IDLE;
						end
					end
					PH_WSLA, PH_WADDR, PH_WDATA: begin
						if (ctx.phase == PH_WDATA ? !(st == ST_DATA_ACK || st == ST_SLAW_ACK)
						                          : !addr_ok) begin
							ctx_next.phase = PH_STOP_FAIL;
						end else if (ctx.phase != PH_WDATA && addr_more) begin
							ctx_next.addr_bytes_sent = ctx.addr_bytes_sent + 3'd1;
							ctx_next.phase           = PH_WADDR;
						end else if (wr_more) begin
							ctx_next.data_index = ctx.data_index + 16'd1;
							ctx_next.remaining  = ctx.remaining - 16'd1;
							ctx_next.phase      = PH_WDATA;
						end else begin
							ctx_next.phase = PH_STOP_OK;
						end
					end
					PH_RSTART: begin
						ctx_next.phase = (st == ST_START || st == ST_RSTART) ? PH_RSLA : PH_IDLE;
					end
					PH_RSLA: begin
						if (st != ST_SLAR_ACK)
							ctx_next.phase = PH_STOP_FAIL;
						else if (ctx.remaining == 16'd0)
							ctx_next.phase = PH_STOP_OK;
						else
							ctx_next.phase = PH_RDATA;
					end
					PH_RDATA: begin
						if (rx_ok) begin
							ctx_next.data_index = ctx.data_index + 16'd1;
							ctx_next.remaining  = rem_dec;
							ctx_next.phase      = rx_last ? PH_STOP_OK : PH_RDATA;
						end else begin
							ctx_next.phase = PH_STOP_FAIL;
						end
					end
					default: begin
						ctx_next.phase = ctx.phase;
					end
				endcase
			end
		endcase
	end

	// result beat
	always_comb begin
		res = '0;
		unique case (item.mode)
			MODE_WRITE, MODE_READ: begin
				res.command = CMD_START;
			end
			MODE_STOP_DONE: begin
				if (stopping) begin
					if (ctx.read_pending) begin
						res.command = CMD_START;
					end else begin
						res.done_res = 1'b1;
						res.failed   = (ctx.phase == PH_STOP_FAIL);
					end
				end
			end
			MODE_EVENT: begin
				unique case (ctx.phase) inside
					PH_WSTART: begin
						if (st == ST_START) begin
							res.command      = CMD_SEND;
							res.command_byte = {ctx.target_addr, 1'b0};
						end else if (ctx.read_pending) begin
							res.command = CMD_START;
						end else begin
							res.done_res = 1'b1;
							res.failed   = 1'b1;
						end
					end
					PH_WSLA, PH_WADDR, PH_WDATA: begin
						if (ctx.phase == PH_WDATA ? !(st == ST_DATA_ACK || st == ST_SLAW_ACK)
						                          : !addr_ok) begin
							res.command = CMD_STOP;
						end else if (ctx.phase != PH_WDATA && addr_more) begin
							res.command      = CMD_SEND;
							res.command_byte = addr_byte;
						end else if (wr_more) begin
							res.command      = CMD_SEND;
							res.command_byte = item.tx_byte;
							res.tx_taken     = 1'b1;
							res.byte_index   = ctx.data_index;
						end else begin
							res.command = CMD_STOP;
						end
					end
					PH_RSTART: begin
						if (st == ST_START || st == ST_RSTART) begin
							res.command      = CMD_SEND;
							res.command_byte = {ctx.target_addr, READ_BIT};
						end else begin
							res.done_res = 1'b1;
							res.failed   = 1'b1;
						end
					end
					PH_RSLA: begin
						if (st != ST_SLAR_ACK || ctx.remaining == 16'd0)
							res.command = CMD_STOP;
						else
							res.command = (ctx.remaining == 16'd1) ? CMD_RX_NACK : CMD_RX_ACK;
					end
					PH_RDATA: begin
						if (rx_ok) begin
							res.rx_valid   = 1'b1;
							res.rx_data    = item.rx_byte;
							res.byte_index = ctx.data_index;
							if (rx_last)
								res.command = CMD_STOP;
							else
								res.command = (rem_dec == 16'd1) ? CMD_RX_NACK : CMD_RX_ACK;
						end else begin
							res.command = CMD_STOP;
						end
					end
					default: begin
						res.command = CMD_NONE;
					end
				endcase
			end
		endcase
	end

endmodule

@@ rtl/i2c_master_register_access_sequencer.sv @@
// ----------------------------------------------------------------------------
// i2c_master_register_access_sequencer
// Sequences start, address, register-address, data and stop commands for a
// byte-level i2c master engine, one command beat per input beat.
// Each accepted input beat passes through the input register, then the step
// logic into the result register, to give its result beat.
// One beat per cycle while res_stall is low; context update is a single step.
// Reset: asynchronous, clears the context to idle and both stages to empty.
// ----------------------------------------------------------------------------
module i2c_master_register_access_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  mode,
	input  logic [6:0]  slave_addr,
	input  logic [31:0] reg_addr,
	input  logic [2:0]  reg_addr_bytes,
	input  logic [15:0] byte_count,
	input  logic [7:0]  bus_status,
	input  logic [7:0]  rx_byte,
	input  logic [7:0]  tx_byte,
	// result channel
	output logic        res_valid,
	input  logic        res_stall,
	output logic [2:0]  command,
	output logic [7:0]  command_byte,
	output logic        tx_taken,
	output logic        rx_valid,
	output logic [7:0]  rx_data,
	output logic [15:0] byte_index,
	output logic        done_res,
	output logic        failed
);
	import i2cmra_pkg::*;

	item_t item_s1;
	logic  valid_s1;
	ctx_t  ctx_q;
	ctx_t  ctx_next;
	res_t  res_next;
	res_t  res_q;
	logic  res_valid_q;
	logic  advance;
	logic  take;

	// stage 1 moves on when the result register is empty or being drained
	assign advance    = valid_s1 && (!res_valid_q || !res_stall);
	assign item_stall = valid_s1 && !advance;
	assign take       = item_valid && !item_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.mode           <= mode_t'(mode);
			item_s1.slave_addr     <= slave_addr;
			item_s1.reg_addr       <= reg_addr;
			item_s1.reg_addr_bytes <= reg_addr_bytes;
			item_s1.byte_count     <= byte_count;
			item_s1.bus_status     <= bus_status;
			item_s1.rx_byte        <= rx_byte;
			item_s1.tx_byte        <= tx_byte;
		end
	end

	// decision logic
	i2cmra_step u_step (
		.item     (item_s1),
		.ctx      (ctx_q),
		.ctx_next (ctx_next),
		.res      (res_next)
	);

	// transaction context
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q <= '{phase: PH_IDLE, default: '0};
		end else if (advance) begin
			ctx_q <= ctx_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_next;
		end
	end

	assign res_valid    = res_valid_q;
	assign command      = res_q.command;
	assign command_byte = res_q.command_byte;
	assign tx_taken     = res_q.tx_taken;
	assign rx_valid     = res_q.rx_valid;
	assign rx_data      = res_q.rx_data;
	assign byte_index   = res_q.byte_index;
	assign done_res     = res_q.done_res;
	assign failed       = res_q.failed;

endmodule
